@@ src/msd_pkg.sv @@
// Shared constants for the multichannel sample delay.
package msd_pkg;

    // Configuration register file
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int DELAY_W   = 16;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Payload port widths
    localparam int CH_IN_W   = 3;
    localparam int SAMPLE_W  = 32;

    // Small queues between and behind the two halves
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

endpackage

@@ src/msd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module msd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/msd_fifo.sv @@
// Four-entry register FIFO used for the command queue and the result queue.
module msd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      pop,
    output logic [WIDTH-1:0]          rdata,
    output logic                      empty,
    output logic                      full,
    output logic [msd_pkg::FIFO_PTR_W:0] count
);

    logic [WIDTH-1:0]                mem_reg [msd_pkg::FIFO_DEPTH];
    logic [msd_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [msd_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [msd_pkg::FIFO_PTR_W:0]    count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (32'(count_reg) == msd_pkg::FIFO_DEPTH);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/msd_front.sv @@
// Front half: accepts samples, tracks channel positions, builds store commands.
module msd_front #(
    parameter int DEPTH       = 65536,
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 32,
    localparam int ADDR_W     = $clog2(CHANNELS * DEPTH),
    localparam int CMD_W      = msd_pkg::CH_IN_W + 2 + 2 * ADDR_W + SAMPLE_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         push,
    input  logic [msd_pkg::CH_IN_W-1:0]                  channel,
    input  logic signed [msd_pkg::SAMPLE_W-1:0]          sample_in,
    output logic                                         full,
    input  logic [msd_pkg::NUM_REGS-1:0][msd_pkg::DELAY_W-1:0] delay,
    input  logic                                         clear_busy,
    output logic                                         cmd_push,
    output logic [CMD_W-1:0]                             cmd_data,
    input  logic                                         cmd_full
);

    localparam int POS_W = $clog2(DEPTH);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef struct packed {
        logic [msd_pkg::CH_IN_W-1:0] ch;
        logic                        write;
        logic                        bypass;
        logic [ADDR_W-1:0]           waddr;
        logic [ADDR_W-1:0]           raddr;
        logic [SAMPLE_BITS-1:0]      sample;
    } cmd_t;

    logic [POS_W-1:0]     pos_reg [CHANNELS];
    logic                 accept;
    logic                 ch_valid;
    logic [CH_W-1:0]      ch_idx;
    logic [msd_pkg::DELAY_W-1:0] d_raw;
    logic [POS_W-1:0]     d_sat;
    logic [POS_W-1:0]     pos;
    logic [POS_W:0]       wsum;
    logic [POS_W-1:0]     wpos;
    logic [POS_W-1:0]     pos_next;
    logic [ADDR_W-1:0]    base;
    cmd_t                 cmd;

    assign full   = cmd_full || clear_busy;
    assign accept = push && !full;

    // Channel lookup and delay saturation
    assign ch_valid = (32'(channel) < CHANNELS);
    assign ch_idx   = channel[CH_W-1:0];
    assign d_raw    = delay[channel];
    assign d_sat    = (32'(d_raw) > DEPTH - 1) ? POS_W'(DEPTH - 1) : POS_W'(d_raw);
    assign pos      = pos_reg[ch_idx];

    // Write position wraps once at most
    assign wsum = {1'b0, pos} + {1'b0, d_sat};
    assign wpos = (32'(wsum) >= DEPTH) ? POS_W'(wsum - (POS_W + 1)'(DEPTH)) : POS_W'(wsum);

    assign pos_next = (32'(pos) == DEPTH - 1) ? '0 : pos + 1'b1;
    assign base     = ADDR_W'(32'(ch_idx) * 32'(DEPTH));

    // Command to the back half
    always_comb
    begin
        cmd.ch     = channel;
        cmd.write  = ch_valid;
        cmd.bypass = !ch_valid || (d_sat == '0);
        cmd.waddr  = base + ADDR_W'(wpos);
        cmd.raddr  = base + ADDR_W'(pos);
        cmd.sample = sample_in[SAMPLE_BITS-1:0];
    end

    assign cmd_push = accept;
    assign cmd_data = cmd;

    // Per-channel read positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else if (accept && ch_valid)
        begin
            pos_reg[ch_idx] <= pos_next;
        end
    end

endmodule

@@ src/msd_back.sv @@
// Back half: clears the store after reset, runs store accesses, queues results.
module msd_back #(
    parameter int DEPTH       = 65536,
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 32,
    localparam int ADDR_W     = $clog2(CHANNELS * DEPTH),
    localparam int CMD_W      = msd_pkg::CH_IN_W + 2 + 2 * ADDR_W + SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_empty,
    input  logic [CMD_W-1:0]                    cmd_data,
    output logic                                cmd_pop,
    output logic                                clear_busy,
    output logic                                empty,
    input  logic                                pop,
    output logic [msd_pkg::CH_IN_W-1:0]         channel_out,
    output logic signed [msd_pkg::SAMPLE_W-1:0] sample_out
);

    localparam int RAM_DEPTH = CHANNELS * DEPTH;
    localparam int RES_W     = msd_pkg::CH_IN_W + SAMPLE_BITS;

    typedef struct packed {
        logic [msd_pkg::CH_IN_W-1:0] ch;
        logic                        write;
        logic                        bypass;
        logic [ADDR_W-1:0]           waddr;
        logic [ADDR_W-1:0]           raddr;
        logic [SAMPLE_BITS-1:0]      sample;
    } cmd_t;

    typedef struct packed {
        logic [msd_pkg::CH_IN_W-1:0] ch;
        logic [SAMPLE_BITS-1:0]      sample;
    } res_t;

    cmd_t                          cmd;
    logic                          clr_active_reg;
    logic [ADDR_W-1:0]             clr_addr_reg;
    logic                          issue;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          s2_valid_reg;
    logic [msd_pkg::CH_IN_W-1:0]   s2_ch_reg;
    logic                          s2_bypass_reg;
    logic [SAMPLE_BITS-1:0]        s2_sample_reg;
    res_t                          res_in;
    res_t                          res_out;
    logic [RES_W-1:0]              res_rdata;
    logic                          res_full;
    logic [msd_pkg::FIFO_PTR_W:0]  res_count;

    assign cmd        = cmd_data;
    assign clear_busy = clr_active_reg;

    // Clearing pass over the whole store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (32'(clr_addr_reg) == RAM_DEPTH - 1)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Issue only when the result queue has room for everything in flight
    assign issue   = !clr_active_reg && !cmd_empty
                     && ((32'(res_count) + 32'(s2_valid_reg)) < msd_pkg::FIFO_DEPTH);
    assign cmd_pop = issue;

    // Store port selection
    assign ram_we    = clr_active_reg || (issue && cmd.write);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : cmd.waddr;
    assign ram_wdata = clr_active_reg ? '0 : cmd.sample;

    msd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (cmd.raddr),
        .rdata (ram_rdata)
    );

    // Read-data stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_ch_reg     <= cmd.ch;
            s2_bypass_reg <= cmd.bypass;
            s2_sample_reg <= cmd.sample;
        end
    end

    // Zero delay and absent channels take the incoming sample
    always_comb
    begin
        res_in.ch     = s2_ch_reg;
        res_in.sample = s2_bypass_reg ? s2_sample_reg : ram_rdata;
    end

    msd_fifo #(
        .WIDTH (RES_W)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s2_valid_reg),
        .wdata (res_in),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty),
        .full  (res_full),
        .count (res_count)
    );

    assign res_out     = res_rdata;
    assign channel_out = res_out.ch;
    assign sample_out  = msd_pkg::SAMPLE_W'(signed'(res_out.sample));

`ifndef ASSERT_OFF
    // A result never arrives at a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) s2_valid_reg |-> !res_full)
        else $error("result pushed into full queue");

    // No command is taken while the clearing pass owns the store
    assert property (@(posedge clk) disable iff (!rst_n) clr_active_reg |-> !cmd_pop)
        else $error("command issued during clearing pass");

    // Queued plus in-flight results stay within the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(res_count) + 32'(s2_valid_reg)) <= msd_pkg::FIFO_DEPTH)
        else $error("result credit overrun");

    // Once the clearing pass ends it does not restart
    assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clearing pass restarted");
`endif

endmodule

@@ src/multichannel_sample_delay.sv @@
// Top level of the multichannel sample delay: register file and both halves.
//
//  Channel   Direction  Handshake            Payload
//  input     in         push / full          channel, sample_in
//  result    out        pop / empty          channel_out, sample_out
//  config    in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One sample is taken per cycle while full is low and one result is delivered per
// cycle while empty is low; the single store with one write and one registered
// read port sets that rate. A result passes the command queue, the read stage and
// the result queue. After reset the store is cleared one word a cycle over all
// CHANNELS*DEPTH words; full stays high for that time and register writes are taken.
// Either side may stall: four-entry queues sit between the halves and at the output.
module multichannel_sample_delay #(
    parameter int DEPTH       = 65536,
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [msd_pkg::CH_IN_W-1:0]         channel,
    input  logic signed [msd_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                empty,
    input  logic                                pop,
    output logic [msd_pkg::CH_IN_W-1:0]         channel_out,
    output logic signed [msd_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msd_pkg::PADDR_W-1:0]         paddr,
    input  logic [msd_pkg::PDATA_W-1:0]         pwdata,
    output logic [msd_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int ADDR_W = $clog2(CHANNELS * DEPTH);
    localparam int CMD_W  = msd_pkg::CH_IN_W + 2 + 2 * ADDR_W + SAMPLE_BITS;

    logic [msd_pkg::NUM_REGS-1:0][msd_pkg::DELAY_W-1:0] delay_reg;
    logic [msd_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;
    logic                          clear_busy;
    logic                          cmd_push;
    logic [CMD_W-1:0]              cmd_wdata;
    logic                          cmd_pop;
    logic [CMD_W-1:0]              cmd_rdata;
    logic                          cmd_empty;
    logic                          cmd_full;
    logic [msd_pkg::FIFO_PTR_W:0]  cmd_count;

    // Delay register file
    assign pready    = 1'b1;
    assign reg_idx   = paddr[msd_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = msd_pkg::PDATA_W'(delay_reg[reg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
        end
        else if (cfg_write)
        begin
            delay_reg[reg_idx] <= pwdata[msd_pkg::DELAY_W-1:0];
        end
    end

    msd_front #(
        .DEPTH       (DEPTH),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .channel    (channel),
        .sample_in  (sample_in),
        .full       (full),
        .delay      (delay_reg),
        .clear_busy (clear_busy),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_wdata),
        .cmd_full   (cmd_full)
    );

    // Command queue between the halves
    msd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty),
        .full  (cmd_full),
        .count (cmd_count)
    );

    msd_back #(
        .DEPTH       (DEPTH),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (cmd_empty),
        .cmd_data    (cmd_rdata),
        .cmd_pop     (cmd_pop),
        .clear_busy  (clear_busy),
        .empty       (empty),
        .pop         (pop),
        .channel_out (channel_out),
        .sample_out  (sample_out)
    );

`ifndef ASSERT_OFF
    // The command queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cmd_count) <= msd_pkg::FIFO_DEPTH)
        else $error("command queue overrun");

    // No sample is taken while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clear_busy |-> full)
        else $error("input open during clearing pass");

    // A taken sample always lands in the command queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> (cmd_push && !cmd_full))
        else $error("accepted sample lost");
`endif

endmodule

@@ tb/sv/multichannel_sample_delay_tb.sv @@
// Self-checking testbench for the multichannel sample delay: driver, monitor and predictor.
module multichannel_sample_delay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 65536;
    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 32;
    localparam int REG_STRIDE  = 4;
    localparam int IDLE_PCT    = 6;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT_A   = 150;
    localparam int HOLD_AT_B   = 480;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [msd_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        msd_pkg::SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    typedef struct packed {
        logic [msd_pkg::CH_IN_W-1:0]         ch;
        logic signed [msd_pkg::SAMPLE_W-1:0] smp;
    } delay_item_t;

    typedef struct packed {
        logic [msd_pkg::CH_IN_W-1:0]         ch;
        logic signed [msd_pkg::SAMPLE_W-1:0] smp;
    } delay_result_t;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 push      = 1'b0;
    logic                                 full;
    logic [msd_pkg::CH_IN_W-1:0]          channel   = '0;
    logic signed [msd_pkg::SAMPLE_W-1:0]  sample_in = '0;
    logic                                 empty;
    logic                                 pop       = 1'b0;
    logic [msd_pkg::CH_IN_W-1:0]          channel_out;
    logic signed [msd_pkg::SAMPLE_W-1:0]  sample_out;
    logic                                 psel      = 1'b0;
    logic                                 penable   = 1'b0;
    logic                                 pwrite    = 1'b0;
    logic [msd_pkg::PADDR_W-1:0]          paddr     = '0;
    logic [msd_pkg::PDATA_W-1:0]          pwdata    = '0;
    logic [msd_pkg::PDATA_W-1:0]          prdata;
    logic                                 pready;

    // Predictor state: delays, per-channel tap positions, sparse delay store
    logic [msd_pkg::DELAY_W-1:0]  delay_cfg   [msd_pkg::NUM_REGS];
    logic [msd_pkg::DELAY_W-1:0]  next_delays [msd_pkg::NUM_REGS];
    logic [15:0]                  tap_pos     [CHANNELS];
    logic [msd_pkg::SAMPLE_W-1:0] history_mem [int unsigned];

    delay_item_t   pending_items[$];
    delay_result_t expected_results[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned hold_left      = 0;
    bit          calm_phase     = 1'b0;

    multichannel_sample_delay #(
        .DEPTH       (DEPTH),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .channel     (channel),
        .sample_in   (sample_in),
        .empty       (empty),
        .pop         (pop),
        .channel_out (channel_out),
        .sample_out  (sample_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Sign-extend a stored word from SAMPLE_BITS to the port width
    function automatic logic [msd_pkg::SAMPLE_W-1:0] widen_sample(
        input logic [msd_pkg::SAMPLE_W-1:0] word);
        logic signed [msd_pkg::SAMPLE_W-1:0] t;
        t = $signed(word << (msd_pkg::SAMPLE_W - SAMPLE_BITS));
        return t >>> (msd_pkg::SAMPLE_W - SAMPLE_BITS);
    endfunction

    // Write the sample ahead of the tap, then read at the tap and advance it; absent channels pass through
    task automatic predict_delayed_sample(input logic [msd_pkg::CH_IN_W-1:0] ch,
                                          input logic [msd_pkg::SAMPLE_W-1:0] smp);
        int unsigned   chn;
        int unsigned   dly;
        int unsigned   rd;
        int unsigned   wr;
        logic [msd_pkg::SAMPLE_W-1:0] word;
        delay_result_t res;
        chn = ch;
        word = smp & SAMPLE_MASK;
        res.ch = ch;
        if (chn >= CHANNELS)
        begin
            res.smp = widen_sample(word);
        end
        else
        begin
            dly = delay_cfg[chn];
            if (dly > DEPTH - 1)
                dly = DEPTH - 1;
            rd = tap_pos[chn] % DEPTH;
            wr = (rd + dly) % DEPTH;
            history_mem[chn * DEPTH + wr] = word;
            if (history_mem.exists(chn * DEPTH + rd))
                res.smp = widen_sample(history_mem[chn * DEPTH + rd]);
            else
                res.smp = '0;
            tap_pos[chn] = 16'((rd + 1) % DEPTH);
        end
        expected_results.push_back(res);
    endtask

    task automatic queue_item(input logic [msd_pkg::CH_IN_W-1:0] ch,
                              input logic [msd_pkg::SAMPLE_W-1:0] smp);
        delay_item_t it;
        it.ch  = ch;
        it.smp = smp;
        pending_items.push_back(it);
    endtask

    function automatic logic [msd_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_items(input int n);
        for (int i = 0; i < n; i++)
            queue_item(msd_pkg::CH_IN_W'($urandom_range(CHANNELS - 1)), pick_sample());
    endtask

    // Wait until every item is sent and every result is back, then let the pipe drain
    task automatic settle_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write every delay register, then read each one back
    task automatic apply_delays();
        for (int i = 0; i < msd_pkg::NUM_REGS; i++)
        begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= msd_pkg::PADDR_W'(i * REG_STRIDE);
            pwdata  <= msd_pkg::PDATA_W'(next_delays[i]);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            delay_cfg[i] = next_delays[i];
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        for (int i = 0; i < msd_pkg::NUM_REGS; i++)
        begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= msd_pkg::PADDR_W'(i * REG_STRIDE);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if (prdata !== msd_pkg::PDATA_W'(delay_cfg[i]))
                report_mismatch($sformatf("delay_ch%0d read %h, wrote %h",
                                          i, prdata, delay_cfg[i]));
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Input driver: predict on each transfer, hold an offer while full
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            channel   <= '0;
            sample_in <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_delayed_sample(channel, sample_in);
                void'(pending_items.pop_front());
            end
            if (!(push && full))
            begin
                if (pending_items.size() != 0 &&
                    (calm_phase || $urandom_range(99) >= IDLE_PCT))
                begin
                    push      <= 1'b1;
                    channel   <= pending_items[0].ch;
                    sample_in <= pending_items[0].smp;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop          <= 1'b0;
            results_seen  = 0;
            hold_left     = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result ch %0d sample %h",
                                              channel_out, sample_out));
                end
                else
                begin
                    if (channel_out !== expected_results[0].ch)
                        report_mismatch($sformatf("result %0d channel_out %0d, want %0d",
                                                  results_seen, channel_out,
                                                  expected_results[0].ch));
                    if (sample_out !== expected_results[0].smp)
                        report_mismatch($sformatf("result %0d sample_out %h, want %h",
                                                  results_seen, sample_out,
                                                  expected_results[0].smp));
                    void'(expected_results.pop_front());
                end
                results_seen++;
                // long back-pressure so the block fills and stalls its input
                if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus and run control
    initial
    begin
        for (int i = 0; i < msd_pkg::NUM_REGS; i++)
        begin
            delay_cfg[i]   = '0;
            next_delays[i] = '0;
        end
        for (int i = 0; i < CHANNELS; i++)
            tap_pos[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Pass-through, short delays and both ends of the range
        next_delays[0] = 16'd0;
        next_delays[1] = 16'd1;
        next_delays[2] = 16'd2;
        next_delays[3] = 16'hFFFF;
        next_delays[4] = 16'd3;
        next_delays[5] = 16'd5;
        next_delays[6] = 16'd0;
        next_delays[7] = 16'hFFFE;
        apply_delays();

        // Directed: sample extremes across every channel; delayed ones start as silence
        for (int i = 0; i < 24; i++)
        begin
            case (i % 6)
                0: queue_item(msd_pkg::CH_IN_W'(i % CHANNELS), 32'h7FFF_FFFF);
                1: queue_item(msd_pkg::CH_IN_W'(i % CHANNELS), 32'h8000_0000);
                2: queue_item(msd_pkg::CH_IN_W'(i % CHANNELS), 32'hFFFF_FFFF);
                3: queue_item(msd_pkg::CH_IN_W'(i % CHANNELS), 32'h0000_0000);
                4: queue_item(msd_pkg::CH_IN_W'(i % CHANNELS), 32'h0000_0001);
                default: queue_item(msd_pkg::CH_IN_W'(i % CHANNELS), 32'hA5A5_5A5A);
            endcase
        end
        settle_idle();

        queue_random_items(180);
        settle_idle();

        // Delays changed mid-stream, history kept; no idling in this phase
        for (int i = 0; i < msd_pkg::NUM_REGS; i++)
            next_delays[i] = msd_pkg::DELAY_W'($urandom_range(12));
        next_delays[0] = 16'hFFFF;
        apply_delays();
        calm_phase = 1'b1;
        queue_random_items(180);
        settle_idle();
        calm_phase = 1'b0;

        for (int i = 0; i < msd_pkg::NUM_REGS; i++)
            next_delays[i] = msd_pkg::DELAY_W'($urandom_range(40));
        next_delays[5] = 16'd0;
        next_delays[6] = 16'hFFFF;
        apply_delays();
        queue_random_items(180);
        settle_idle();

        for (int i = 0; i < msd_pkg::NUM_REGS; i++)
            next_delays[i] = msd_pkg::DELAY_W'(i * 3);
        next_delays[7] = msd_pkg::DELAY_W'($urandom);
        apply_delays();
        queue_random_items(190);
        settle_idle();

        if (mismatch_count == 0)
            $display("multichannel_sample_delay verification clean");
        else
            $display("multichannel_sample_delay verification failed");
        $finish;
    end

    // Watchdog: covers the store clear after reset and a slow stalled run
    initial
    begin
        #40_000_000;
        $display("multichannel_sample_delay verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/msd_pkg.sv
src/msd_ram.sv
src/msd_fifo.sv
src/msd_front.sv
src/msd_back.sv
src/multichannel_sample_delay.sv
tb/sv/multichannel_sample_delay_tb.sv
